/* src/mdec_pkg.sv */
package mdec_pkg;

  // Mask byte width and the value that marks a set pixel
  localparam int unsigned PIXEL_BITS = 8;
  localparam logic [PIXEL_BITS-1:0] SET_VALUE = 8'd255;

  // Classification flags carried with each request through the queue
  typedef struct packed {
    logic counted;
    logic eof;
  } mdec_flags_t;

  localparam int unsigned FLAGS_BITS = $bits(mdec_flags_t);

endpackage

/* src/mdec_front.sv */
module mdec_front #(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mdec_pkg::PIXEL_BITS-1:0]   pixel_value,
  input  logic [COORD_BITS-1:0]             row,
  input  logic [COORD_BITS-1:0]             col,
  input  logic                              end_of_frame,
  output logic                              q_valid,
  input  logic                              q_ready,
  output mdec_pkg::mdec_flags_t             q_flags,
  output logic [COORD_BITS-1:0]             q_x,
  output logic [COORD_BITS-1:0]             q_y
);

  logic                  valid;
  mdec_pkg::mdec_flags_t flags;
  logic [COORD_BITS-1:0] x;
  logic [COORD_BITS-1:0] y;

  assign in_ready = !valid || q_ready;
  assign q_valid  = valid;
  assign q_flags  = flags;
  assign q_x      = x;
  assign q_y      = y;

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Classify: set value, off row 0 and column 0
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      flags.counted <= (pixel_value == mdec_pkg::SET_VALUE) &&
                       (col != '0) && (row != '0);
      flags.eof     <= end_of_frame;
      x             <= col;
      y             <= row;
    end
  end

endmodule

/* src/mdec_fifo.sv */
module mdec_fifo #(
  parameter int unsigned WIDTH = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned DEPTH = 2;

  logic [WIDTH-1:0] mem [DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign push_ready = (count != 2'(DEPTH));
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* src/mdec_back.sv */
module mdec_back #(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  mdec_pkg::mdec_flags_t q_flags,
  input  logic [COORD_BITS-1:0] q_x,
  input  logic [COORD_BITS-1:0] q_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  found,
  output logic [COORD_BITS-1:0] top_left_x,
  output logic [COORD_BITS-1:0] top_left_y,
  output logic [COORD_BITS-1:0] top_right_x,
  output logic [COORD_BITS-1:0] top_right_y,
  output logic [COORD_BITS-1:0] bottom_right_x,
  output logic [COORD_BITS-1:0] bottom_right_y,
  output logic [COORD_BITS-1:0] bottom_left_x,
  output logic [COORD_BITS-1:0] bottom_left_y
);

  localparam int unsigned SUM_BITS = COORD_BITS + 1;

  // Running extremes
  logic                       any_counted;
  logic [SUM_BITS-1:0]        best_min_sum;
  logic [SUM_BITS-1:0]        best_max_sum;
  logic signed [SUM_BITS-1:0] best_x_minus_y;
  logic signed [SUM_BITS-1:0] best_y_minus_x;
  logic [COORD_BITS-1:0]      tl_x, tl_y, tr_x, tr_y, br_x, br_y, bl_x, bl_y;

  logic                       any_counted_next;
  logic [SUM_BITS-1:0]        best_min_sum_next;
  logic [SUM_BITS-1:0]        best_max_sum_next;
  logic signed [SUM_BITS-1:0] best_x_minus_y_next;
  logic signed [SUM_BITS-1:0] best_y_minus_x_next;
  logic [COORD_BITS-1:0]      tl_x_next, tl_y_next, tr_x_next, tr_y_next;
  logic [COORD_BITS-1:0]      br_x_next, br_y_next, bl_x_next, bl_y_next;

  logic [SUM_BITS-1:0]        sum;
  logic signed [SUM_BITS-1:0] xmy;
  logic signed [SUM_BITS-1:0] ymx;
  logic                       go;
  logic                       emit;

  // An end-of-frame request waits only for a free output register
  assign q_ready = !q_flags.eof || !out_valid || out_ready;
  assign go      = q_valid && q_ready;
  assign emit    = go && q_flags.eof;

  assign sum = {1'b0, q_x} + {1'b0, q_y};
  assign xmy = $signed({1'b0, q_x}) - $signed({1'b0, q_y});
  assign ymx = $signed({1'b0, q_y}) - $signed({1'b0, q_x});

  // Strict compares: the first pixel in raster order keeps a tie
  always_comb begin
    any_counted_next    = any_counted;
    best_min_sum_next   = best_min_sum;
    best_max_sum_next   = best_max_sum;
    best_x_minus_y_next = best_x_minus_y;
    best_y_minus_x_next = best_y_minus_x;
    tl_x_next = tl_x;
    tl_y_next = tl_y;
    tr_x_next = tr_x;
    tr_y_next = tr_y;
    br_x_next = br_x;
    br_y_next = br_y;
    bl_x_next = bl_x;
    bl_y_next = bl_y;
    if (q_flags.counted) begin
      any_counted_next = 1'b1;
      if (!any_counted || (sum < best_min_sum)) begin
        best_min_sum_next = sum;
        tl_x_next = q_x;
        tl_y_next = q_y;
      end
      if (!any_counted || (xmy > best_x_minus_y)) begin
        best_x_minus_y_next = xmy;
        tr_x_next = q_x;
        tr_y_next = q_y;
      end
      if (!any_counted || (sum > best_max_sum)) begin
        best_max_sum_next = sum;
        br_x_next = q_x;
        br_y_next = q_y;
      end
      if (!any_counted || (ymx > best_y_minus_x)) begin
        best_y_minus_x_next = ymx;
        bl_x_next = q_x;
        bl_y_next = q_y;
      end
    end
  end

  // Frame state; cleared when the frame's end-of-frame request is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      any_counted <= 1'b0;
    end else if (go) begin
      any_counted <= emit ? 1'b0 : any_counted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      best_min_sum   <= best_min_sum_next;
      best_max_sum   <= best_max_sum_next;
      best_x_minus_y <= best_x_minus_y_next;
      best_y_minus_x <= best_y_minus_x_next;
      tl_x <= tl_x_next;
      tl_y <= tl_y_next;
      tr_x <= tr_x_next;
      tr_y <= tr_y_next;
      br_x <= br_x_next;
      br_y <= br_y_next;
      bl_x <= bl_x_next;
      bl_y <= bl_y_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Empty frame reports zero coordinates
  always_ff @(posedge clk) begin
    if (emit) begin
      found          <= any_counted_next;
      top_left_x     <= any_counted_next ? tl_x_next : '0;
      top_left_y     <= any_counted_next ? tl_y_next : '0;
      top_right_x    <= any_counted_next ? tr_x_next : '0;
      top_right_y    <= any_counted_next ? tr_y_next : '0;
      bottom_right_x <= any_counted_next ? br_x_next : '0;
      bottom_right_y <= any_counted_next ? br_y_next : '0;
      bottom_left_x  <= any_counted_next ? bl_x_next : '0;
      bottom_left_y  <= any_counted_next ? bl_y_next : '0;
    end
  end

endmodule

/* src/mask_diagonal_extreme_corners.sv */
// After its end-of-frame pixel is accepted, a frame's result passes the classify register,
// the 2-entry queue, then the extreme update into the output register, where it is valid.
// Throughput: 1 pixel per cycle, set by the compare/update of the back end, while no
// end-of-frame pixel waits for a held result to be taken.
// The output register lets the next frame's pixels flow while a result waits to be taken.
// Reset (rst, synchronous): empties the queue, drops the pending result, clears found state.
module mask_diagonal_extreme_corners #(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mdec_pkg::PIXEL_BITS-1:0]   pixel_value,
  input  logic [COORD_BITS-1:0]             row,
  input  logic [COORD_BITS-1:0]             col,
  input  logic                              end_of_frame,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic [COORD_BITS-1:0]             top_left_x,
  output logic [COORD_BITS-1:0]             top_left_y,
  output logic [COORD_BITS-1:0]             top_right_x,
  output logic [COORD_BITS-1:0]             top_right_y,
  output logic [COORD_BITS-1:0]             bottom_right_x,
  output logic [COORD_BITS-1:0]             bottom_right_y,
  output logic [COORD_BITS-1:0]             bottom_left_x,
  output logic [COORD_BITS-1:0]             bottom_left_y
);

  localparam int unsigned Q_WIDTH = mdec_pkg::FLAGS_BITS + 2 * COORD_BITS;

  logic                  f_valid;
  logic                  f_ready;
  mdec_pkg::mdec_flags_t f_flags;
  logic [COORD_BITS-1:0] f_x;
  logic [COORD_BITS-1:0] f_y;
  logic                  b_valid;
  logic                  b_ready;
  logic [Q_WIDTH-1:0]    b_data;
  mdec_pkg::mdec_flags_t b_flags;
  logic [COORD_BITS-1:0] b_x;
  logic [COORD_BITS-1:0] b_y;

  assign b_flags = mdec_pkg::mdec_flags_t'(b_data[Q_WIDTH-1 -: mdec_pkg::FLAGS_BITS]);
  assign b_x     = b_data[2*COORD_BITS-1:COORD_BITS];
  assign b_y     = b_data[COORD_BITS-1:0];

  // Front end: accept and classify
  mdec_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_value  (pixel_value),
    .row          (row),
    .col          (col),
    .end_of_frame (end_of_frame),
    .q_valid      (f_valid),
    .q_ready      (f_ready),
    .q_flags      (f_flags),
    .q_x          (f_x),
    .q_y          (f_y)
  );

  // Decoupling queue
  mdec_fifo #(.WIDTH(Q_WIDTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_flags, f_x, f_y}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  // Back end: track extremes and emit per frame
  mdec_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (b_valid),
    .q_ready        (b_ready),
    .q_flags        (b_flags),
    .q_x            (b_x),
    .q_y            (b_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .top_left_x     (top_left_x),
    .top_left_y     (top_left_y),
    .top_right_x    (top_right_x),
    .top_right_y    (top_right_y),
    .bottom_right_x (bottom_right_x),
    .bottom_right_y (bottom_right_y),
    .bottom_left_x  (bottom_left_x),
    .bottom_left_y  (bottom_left_y)
  );

endmodule
